### rtl/udlp_pkg.sv
// Shared types, character codes and line layout for the date-time line parser.
// Self-contained; imported by uart_datetime_line_parser.
`default_nettype none

package udlp_pkg;

	// Line layout: DD/MM/YYYY HH:MM:SS
	localparam int unsigned LINE_LEN      = 19;
	localparam int unsigned LINE_IDX_W    = $clog2(LINE_LEN);
	localparam int unsigned NUM_FIELDS    = 7;
	localparam int unsigned BUFFER_DEPTH_DEF = 32;

	localparam logic [LINE_LEN-1:0] DIGIT_MASK = 19'b110_1101_1011_1101_1011;
	localparam logic [LINE_LEN-1:0] SLASH_MASK = 19'b000_0000_0000_0010_0100;
	localparam logic [LINE_LEN-1:0] COLON_MASK = 19'b001_0010_0000_0000_0000;
	localparam logic [LINE_LEN-1:0] SPACE_MASK = 19'b000_0000_0100_0000_0000;

	// First position of each two-digit field: day, month, century, year, hour, min, sec
	localparam int unsigned FIELD_POS [NUM_FIELDS] = '{0, 3, 6, 8, 11, 14, 17};

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [7:0] END_CODE_RST   = 8'd13;
	localparam logic [7:0] ERASE_CODE_RST = 8'd127;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CODE = 1'b1;

	typedef logic [6:0] field_t;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_char;
		logic       erase_notice;
		logic       line_done;
		logic       format_ok;
		field_t     day;
		field_t     month;
		field_t     century;
		field_t     year_in_century;
		field_t     hour;
		field_t     minute;
		field_t     second;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	// Two ASCII digits to a value 0..99
	function automatic field_t pair_value(input logic [7:0] hi, input logic [7:0] lo);
		return field_t'({3'b000, hi[3:0]} * 7'd10 + {3'b000, lo[3:0]});
	endfunction

endpackage

`default_nettype wire

### rtl/uart_datetime_line_parser.sv
// Date-time line parser: edits a received line and checks DD/MM/YYYY HH:MM:SS.
// A result word is registered in the output register, or in the skid behind it.
// Throughput: one character per cycle; a one-word skid stage keeps input open while
// the output word waits, so input stalls only when both output and skid are occupied.
// Reset: fill count cleared, end code 13, erase code 127, output and skid empty;
// the line store is not cleared (positions are always written before being read).
`default_nettype none

module uart_datetime_line_parser
	import udlp_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data,
	// character input
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           char_code,
	// result output
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      echo_valid,
	output logic [7:0]                echo_char,
	output logic                      erase_notice,
	output logic                      line_done,
	output logic                      format_ok,
	output logic [6:0]                day,
	output logic [6:0]                month,
	output logic [6:0]                century,
	output logic [6:0]                year_in_century,
	output logic [6:0]                hour,
	output logic [6:0]                minute,
	output logic [6:0]                second
);

	// Counter must hold BUFFER_DEPTH itself, since the count saturates there.
	localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_LINE = CNT_W'(LINE_LEN);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(BUFFER_DEPTH);

	// Configuration registers
	logic [7:0] end_code_q;
	logic [7:0] erase_code_q;

	// Line state: store has no reset, positions below the count are always valid
	logic [7:0]       line_store_q [LINE_LEN];
	logic [CNT_W-1:0] fill_q;

	// Output register and skid stage
	result_t out_q;
	logic    out_valid_q;
	result_t skid_q;
	logic    skid_valid_q;

	logic    take;       // character word taken this cycle
	logic    push;       // taken and produces a result (nonzero)
	logic    pop;        // output word leaves this cycle
	logic    is_end;
	logic    is_erase;
	logic    store_wr;
	logic    fmt_ok;
	logic [CNT_W-1:0] fill_nxt;
	field_t  fields [NUM_FIELDS];
	result_t new_res;

	assign in_stall = skid_valid_q;
	assign take     = in_valid && !in_stall;
	assign push     = take && (char_code != CHAR_NUL);
	assign pop      = out_valid_q && !out_stall;

	// End code takes precedence over erase code when both match
	assign is_end   = (char_code == end_code_q);
	assign is_erase = !is_end && (char_code == erase_code_q);

	// Format check over the whole stored line, position by position
	always_comb begin
		fmt_ok = (fill_q == CNT_LINE);
		for (int p = 0; p < LINE_LEN; p++) begin
			if (DIGIT_MASK[p]) begin
				fmt_ok = fmt_ok && is_digit(line_store_q[p]);
			end
			if (SLASH_MASK[p]) begin
				fmt_ok = fmt_ok && (line_store_q[p] == CHAR_SLASH);
			end
			if (COLON_MASK[p]) begin
				fmt_ok = fmt_ok && (line_store_q[p] == CHAR_COLON);
			end
			if (SPACE_MASK[p]) begin
				fmt_ok = fmt_ok && (line_store_q[p] == CHAR_SPACE);
			end
		end
	end

	// Decode each field; zeroed when the line is not a valid date-time
	always_comb begin
		for (int k = 0; k < NUM_FIELDS; k++) begin
			fields[k] = fmt_ok ? pair_value(line_store_q[FIELD_POS[k]],
				line_store_q[FIELD_POS[k] + 1]) : '0;
		end
	end

	// Next count, and whether this character lands in the store
	always_comb begin
		fill_nxt = fill_q;
		store_wr = 1'b0;
		if (is_end) begin
			fill_nxt = '0;
		end else if (is_erase) begin
			if (fill_q != '0) begin
				fill_nxt = fill_q - 1'b1;
			end
		end else if (fill_q < CNT_MAX) begin
			fill_nxt = fill_q + 1'b1;
			store_wr = (fill_q < CNT_LINE);
		end
	end

	// Assemble the result word for this character
	always_comb begin
		new_res                 = '0;
		new_res.echo_valid      = !is_end;
		new_res.echo_char       = is_end ? CHAR_NUL : char_code;
		new_res.erase_notice    = is_erase && (fill_q != '0);
		new_res.line_done       = is_end;
		new_res.format_ok       = is_end && fmt_ok;
		if (is_end) begin
			new_res.day             = fields[0];
			new_res.month           = fields[1];
			new_res.century         = fields[2];
			new_res.year_in_century = fields[3];
			new_res.hour            = fields[4];
			new_res.minute          = fields[5];
			new_res.second          = fields[6];
		end
	end

	// Configuration: the user must write only while idle; the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_code_q   <= END_CODE_RST;
			erase_code_q <= ERASE_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_END_CODE:   end_code_q   <= cfg_data;
				CFG_ERASE_CODE: erase_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Fill count: advance, drop or clear on each nonzero character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push) begin
			fill_q <= fill_nxt;
		end
	end

	// Line store: write the character at the current fill position
	always_ff @(posedge clk) begin
		for (int p = 0; p < LINE_LEN; p++) begin
			if (push && store_wr && (fill_q[LINE_IDX_W-1:0] == LINE_IDX_W'(p))) begin
				line_store_q[p] <= char_code;
			end
		end
	end

	// Output register with skid: park a new word in the skid while output is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : new_res;
		end else if (push) begin
			skid_q <= new_res;
		end
	end

	assign out_valid       = out_valid_q;
	assign echo_valid      = out_q.echo_valid;
	assign echo_char       = out_q.echo_char;
	assign erase_notice    = out_q.erase_notice;
	assign line_done       = out_q.line_done;
	assign format_ok       = out_q.format_ok;
	assign day             = out_q.day;
	assign month           = out_q.month;
	assign century         = out_q.century;
	assign year_in_century = out_q.year_in_century;
	assign hour            = out_q.hour;
	assign minute          = out_q.minute;
	assign second          = out_q.second;

	// The skid only fills behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a word while output is empty");

	// Count never passes the buffer depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_MAX)
		else $error("fill count beyond buffer depth");

	// A closed line is never echoed, every other word is
	a_echo_vs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.echo_valid != out_q.line_done))
		else $error("echo and line end both set or both clear");

	// A valid format only comes with a closed line
	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.format_ok |-> out_q.line_done)
		else $error("format ok without line end");

	// An end code always empties the line
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && is_end |=> fill_q == '0)
		else $error("line not cleared after end code");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for uart_datetime_line_parser: characters drive line editing,
// erasing and date-time parsing against a local model of the line and its two code registers.
// Depends on udlp_pkg for the result layout, code register indexes and character constants.

module testbench;
	import udlp_pkg::*;

	localparam int LINE_CAP      = 32;
	localparam int TIMEOUT_TICKS = 12 * 400000;
	localparam int DRAIN_CYCLES  = 4;

	// 'N' marks a digit slot; every other byte must match exactly
	localparam logic [8*19-1:0] DATETIME_LAYOUT = "NN/NN/NNNN NN:NN:NN";

	typedef enum {
		LINE_GOOD,
		LINE_CORRUPT,
		LINE_EDITED,
		LINE_OVERRUN,
		LINE_SHORT,
		LINE_NOISE
	} line_kind_e;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC,
		STALL_BURSTY
	} stall_pattern_e;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           char_code;
	logic                 out_valid;
	logic                 out_stall;
	logic                 echo_valid;
	logic [7:0]           echo_char;
	logic                 erase_notice;
	logic                 line_done;
	logic                 format_ok;
	logic [6:0]           day;
	logic [6:0]           month;
	logic [6:0]           century;
	logic [6:0]           year_in_century;
	logic [6:0]           hour;
	logic [6:0]           minute;
	logic [6:0]           second;

	// Local copy of the line editor and its registers
	logic [7:0] line_buf [0:18];
	int         fill_level;
	logic [7:0] end_reg;
	logic [7:0] erase_reg;

	result_t line_results_due [$];
	int      mismatches;
	int      stim_count;

	// Sender burst control
	int burst_left;
	bit sender_gaps;

	// Receiver stall pattern, owned by its own process
	int             hold_request;
	int             hold_left;
	int             stall_tick;
	int             stall_run;
	stall_pattern_e stall_mode;

	uart_datetime_line_parser #(
		.BUFFER_DEPTH(LINE_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.echo_valid(echo_valid),
		.echo_char(echo_char),
		.erase_notice(erase_notice),
		.line_done(line_done),
		.format_ok(format_ok),
		.day(day),
		.month(month),
		.century(century),
		.year_in_century(year_in_century),
		.hour(hour),
		.minute(minute),
		.second(second)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Layout byte expected at line position p
	function automatic logic [7:0] layout_char(input int p);
		return DATETIME_LAYOUT[8*(18-p) +: 8];
	endfunction

	// Only a line of exactly 19 characters matching the layout counts as a date-time
	function automatic bit line_is_datetime();
		logic [7:0] want;
		if (fill_level != LINE_LEN)
			return 1'b0;
		for (int p = 0; p < LINE_LEN; p++) begin
			want = layout_char(p);
			if (want == "N") begin
				if (line_buf[p] < "0" || line_buf[p] > "9")
					return 1'b0;
			end else if (line_buf[p] != want) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic field_t two_digit_at(input int p);
		int tens;
		int units;
		tens  = int'(line_buf[p]) - 48;
		units = int'(line_buf[p+1]) - 48;
		return field_t'(tens * 10 + units);
	endfunction

	// Work out the word a character produces and advance the local line
	function automatic void predict_line_edit(input logic [7:0] c);
		result_t r;
		// a zero byte is not a character at all: no word, no change
		if (c == CHAR_NUL)
			return;
		r = '0;
		if (c == end_reg) begin
			// end code wins over the erase code when the two are equal
			r.line_done = 1'b1;
			if (line_is_datetime()) begin
				r.format_ok       = 1'b1;
				r.day             = two_digit_at(0);
				r.month           = two_digit_at(3);
				r.century         = two_digit_at(6);
				r.year_in_century = two_digit_at(8);
				r.hour            = two_digit_at(11);
				r.minute          = two_digit_at(14);
				r.second          = two_digit_at(17);
			end
			fill_level = 0;
		end else begin
			if (c == erase_reg) begin
				// erase on an empty line is echoed but changes nothing
				if (fill_level > 0) begin
					r.erase_notice = 1'b1;
					fill_level--;
				end
			end else if (fill_level < LINE_CAP) begin
				// past position 18 the count still runs, but nothing is stored
				if (fill_level < LINE_LEN)
					line_buf[fill_level] = c;
				fill_level++;
			end
			r.echo_valid = 1'b1;
			r.echo_char  = c;
		end
		line_results_due.push_back(r);
	endfunction

	function automatic string format_result(input result_t r);
		return $sformatf("echo=%0b/%02h erase=%0b done=%0b ok=%0b %0d/%0d/%0d|%0d %0d:%0d:%0d",
			r.echo_valid, r.echo_char, r.erase_notice, r.line_done, r.format_ok,
			r.day, r.month, r.century, r.year_in_century, r.hour, r.minute, r.second);
	endfunction

	function automatic string differing_fields(input result_t got, input result_t want);
		string s;
		s = "";
		if (got.echo_valid !== want.echo_valid)           s = {s, " echo_valid"};
		if (got.echo_char !== want.echo_char)             s = {s, " echo_char"};
		if (got.erase_notice !== want.erase_notice)       s = {s, " erase_notice"};
		if (got.line_done !== want.line_done)             s = {s, " line_done"};
		if (got.format_ok !== want.format_ok)             s = {s, " format_ok"};
		if (got.day !== want.day)                         s = {s, " day"};
		if (got.month !== want.month)                     s = {s, " month"};
		if (got.century !== want.century)                 s = {s, " century"};
		if (got.year_in_century !== want.year_in_century) s = {s, " year_in_century"};
		if (got.hour !== want.hour)                       s = {s, " hour"};
		if (got.minute !== want.minute)                   s = {s, " minute"};
		if (got.second !== want.second)                   s = {s, " second"};
		return s;
	endfunction

	// Check every word taken from the output against the oldest prediction
	always @(posedge clk) begin
		result_t got;
		result_t want;
		string   diff;
		if (arst_n && out_valid && !out_stall) begin
			got = '{echo_valid, echo_char, erase_notice, line_done, format_ok,
				day, month, century, year_in_century, hour, minute, second};
			if (line_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: %s", format_result(got));
			end else begin
				want = line_results_due.pop_front();
				diff = differing_fields(got, want);
				if (diff != "") begin
					mismatches++;
					if (mismatches <= 10)
						$display("bad word (%s)\n  expected %s\n  actual   %s",
							diff, format_result(want), format_result(got));
				end
			end
		end
	end

	// Receiver: a long hold when asked for, otherwise a pattern that changes now and then
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		stall_tick++;
		if (stall_tick % 97 == 0)
			stall_mode = stall_pattern_e'($urandom_range(0, 4));
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:     out_stall <= 1'b0;
				STALL_LIGHT:    out_stall <= ($urandom_range(0, 4) == 0);
				STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: out_stall <= (stall_tick % 3 == 0);
				default: begin
					if (stall_run > 0) begin
						stall_run--;
						out_stall <= 1'b1;
					end else if ($urandom_range(0, 5) == 0) begin
						stall_run = $urandom_range(1, 12);
						out_stall <= 1'b1;
					end else begin
						out_stall <= 1'b0;
					end
				end
			endcase
		end
	end

	// Offer one character and hold it until it is taken; returns on the next falling edge
	task automatic send_char(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (sender_gaps && gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		char_code <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_line_edit(c);
		if (c != CHAR_NUL)
			stim_count++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Drop valid and wait for every predicted word, then let the pipeline settle
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (line_results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_code_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		wait_results_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_END_CODE)
			end_reg = val;
		else
			erase_reg = val;
	endtask

	task automatic set_codes(input logic [7:0] end_val, input logic [7:0] erase_val);
		write_code_reg(CFG_END_CODE, end_val);
		write_code_reg(CFG_ERASE_CODE, erase_val);
	endtask

	// Any nonzero byte that is neither code, so it always counts as a plain character
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = $urandom_range(1, 255);
		while (c == end_reg || c == erase_reg);
		return c;
	endfunction

	function automatic line_kind_e pick_line_kind();
		int roll;
		roll = $urandom_range(0, 15);
		if (roll < 6)  return LINE_GOOD;
		if (roll < 8)  return LINE_CORRUPT;
		if (roll < 10) return LINE_EDITED;
		if (roll < 12) return LINE_OVERRUN;
		if (roll < 14) return LINE_SHORT;
		return LINE_NOISE;
	endfunction

	// Build one line of the given kind with random content and close it with the end code
	task automatic send_line(input line_kind_e kind);
		logic [7:0] txt [$];
		logic [7:0] lc;
		int         extra;
		for (int p = 0; p < LINE_LEN; p++) begin
			lc = layout_char(p);
			txt.push_back(lc == "N" ? 8'(8'h30 + $urandom_range(0, 9)) : lc);
		end
		case (kind)
			LINE_CORRUPT: txt[$urandom_range(0, LINE_LEN-1)] = plain_char();
			LINE_SHORT:   repeat ($urandom_range(1, LINE_LEN)) void'(txt.pop_back());
			LINE_NOISE: begin
				txt.delete();
				repeat ($urandom_range(0, 24)) txt.push_back(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
		if (kind == LINE_EDITED && $urandom_range(0, 1) == 0)
			send_char(erase_reg);
		foreach (txt[i]) begin
			// slip in a stray character and take it back again
			if (kind == LINE_EDITED && $urandom_range(0, 3) == 0) begin
				send_char(plain_char());
				send_char(erase_reg);
			end
			if ($urandom_range(0, 39) == 0)
				send_char(CHAR_NUL);
			send_char(txt[i]);
		end
		if (kind == LINE_OVERRUN) begin
			// run past the store, often past the count limit, then maybe back to 19
			extra = $urandom_range(1, 20);
			repeat (extra) send_char(plain_char());
			if ($urandom_range(0, 3) != 0)
				repeat (((LINE_LEN + extra) < LINE_CAP ? LINE_LEN + extra : LINE_CAP) - LINE_LEN)
					send_char(erase_reg);
		end
		send_char(end_reg);
	endtask

	task automatic test_erase_cases();
		send_char(erase_reg);   // erase on an empty line
		send_char(CHAR_NUL);    // zero byte, no word
		send_char("7");
		send_char(erase_reg);   // erase with notice
		send_char("1");
		send_char(end_reg);     // wrong length
	endtask

	task automatic test_datetime_extremes();
		// 9 against 0 in both orders, 00 and 99 in the year, then 00 in every field
		send_text("09/90/0099 90:09:99");
		send_char(end_reg);
		send_text("00/00/0000 00:00:00");
		send_char(end_reg);
	endtask

	task automatic test_code_registers();
		set_codes(8'h0A, 8'h08);
		repeat (4) send_line(pick_line_kind());
		set_codes(8'hFF, 8'h00);        // erase unreachable: zero is no character
		repeat (4) send_line(pick_line_kind());
		set_codes(8'h00, 8'hFF);        // lines never close
		repeat (2) send_line(pick_line_kind());
		set_codes(8'h7E, 8'h7E);        // same code: end wins
		repeat (4) send_line(LINE_EDITED);
		set_codes(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
		repeat (4) send_line(pick_line_kind());
		set_codes(END_CODE_RST, ERASE_CODE_RST);
	endtask

	task automatic test_backpressure();
		wait_results_drained();
		sender_gaps  = 1'b0;
		hold_request = 80;
		// keep offering while the receiver holds off, so the input stalls
		send_line(LINE_GOOD);
		send_line(LINE_OVERRUN);
		wait_results_drained();
		sender_gaps = 1'b1;
	endtask

	task automatic test_random_lines();
		while (stim_count < 950) begin
			sender_gaps = ($urandom_range(0, 7) != 0);
			send_line(pick_line_kind());
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_END_CODE;
		cfg_data     = 8'h00;
		in_valid     = 1'b0;
		char_code    = 8'h00;
		out_stall    = 1'b0;
		end_reg      = END_CODE_RST;
		erase_reg    = ERASE_CODE_RST;
		fill_level   = 0;
		mismatches   = 0;
		stim_count   = 0;
		burst_left   = 0;
		sender_gaps  = 1'b1;
		hold_request = 0;
		hold_left    = 0;
		stall_tick   = 0;
		stall_run    = 0;
		stall_mode   = STALL_NONE;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_erase_cases();
		test_datetime_extremes();
		stim_count = 0;
		test_code_registers();
		test_backpressure();
		test_random_lines();

		wait_results_drained();
		if (mismatches == 0 && line_results_due.size() == 0)
			$display("uart_datetime_line_parser: match");
		else
			$display("uart_datetime_line_parser: mismatch");
		$finish;
	end

	initial begin
		#(TIMEOUT_TICKS);
		$display("uart_datetime_line_parser: mismatch");
		$finish;
	end

endmodule

### sim.f
rtl/udlp_pkg.sv
rtl/uart_datetime_line_parser.sv
tb/testbench.sv
